>>> hdl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSV converter
// Pixel and result word formats, and the word handed along the divider chain.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Field widths
  localparam int CH_BITS  = 8;
  localparam int HUE_BITS = 16;

  // Quotient bits produced by the chain: the wider of the two result fields.
  localparam int QUO_BITS = (HUE_BITS > CH_BITS) ? HUE_BITS : CH_BITS;

  // Remainder widths: hue divisor is 6*delta, saturation divisor is 2*max.
  localparam int HREM_W = CH_BITS + 3;
  localparam int SREM_W = CH_BITS + 1;

  // Input word
  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } rhc_pixel_t;

  // Result word
  typedef struct packed {
    logic [HUE_BITS-1:0] hue;
    logic [CH_BITS-1:0]  saturation;
    logic [CH_BITS-1:0]  brightness;
  } rhc_hsv_t;

  // Word carried from cell to cell: two restoring divisions in flight.
  // The *_q fields hold unused dividend bits on top and quotient bits below.
  typedef struct packed {
    logic [HREM_W-1:0]   hue_rem;
    logic [HREM_W-1:0]   hue_div;
    logic [QUO_BITS-1:0] hue_q;
    logic [SREM_W-1:0]   sat_rem;
    logic [SREM_W-1:0]   sat_div;
    logic [QUO_BITS-1:0] sat_q;
    logic [CH_BITS-1:0]  bright;
  } rhc_div_t;

endpackage

>>> hdl/rgb_to_hsv_convert_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core: pipelined RGB to HSV conversion
// Front stage finds max/min and sets up two divisions; a chain of identical
// cells then produces one quotient bit of hue and of saturation per cell.
//
//   channel  dir  word          fields
//   pixel    in   rhc_pixel_t   red, green, blue
//   hsv      out  rhc_hsv_t     hue, saturation, brightness
//
// The pipeline is the front stage plus one cell per quotient bit. One pixel is
// taken per clock while the chain is not blocked; no pixel waits on another.
// Every stage holds its word while the next is full and fills any bubble, so
// pixels are still taken while a finished result waits on hsv_stall, until
// every stage of the chain holds a word.
// rst is synchronous and clears only the stage valid bits.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  rhc_pkg::rhc_pixel_t pixel,
  output logic                hsv_valid,
  input  logic                hsv_stall,
  output rhc_pkg::rhc_hsv_t   hsv
);
  import rhc_pkg::*;

  logic                front_ready;
  logic [QUO_BITS:0]   valid_chain;
  logic [QUO_BITS:0]   ready_chain;
  rhc_div_t            word_chain [QUO_BITS+1];

  // Front stage
  rhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pixel_valid),
    .pixel      (pixel),
    .ready      (front_ready),
    .out_valid  (valid_chain[0]),
    .out_data   (word_chain[0]),
    .next_ready (ready_chain[0])
  );

  assign pixel_stall = !front_ready;

  // Divider cells, one quotient bit each
  for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (valid_chain[i]),
      .in_data    (word_chain[i]),
      .ready      (ready_chain[i]),
      .out_valid  (valid_chain[i+1]),
      .out_data   (word_chain[i+1]),
      .next_ready (ready_chain[i+1])
    );
  end

  // Result from the last cell; quotients are trimmed to field width
  assign ready_chain[QUO_BITS] = !hsv_stall;
  assign hsv_valid             = valid_chain[QUO_BITS];
  assign hsv.hue        = word_chain[QUO_BITS].hue_q[QUO_BITS-1 -: HUE_BITS];
  assign hsv.saturation = word_chain[QUO_BITS].sat_q[QUO_BITS-1 -: CH_BITS];
  assign hsv.brightness = word_chain[QUO_BITS].bright;

  // Black gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv.brightness == '0) |-> (hsv.hue == '0 && hsv.saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  // A word marked gray by its unit saturation divisor gives zero hue and saturation
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && word_chain[QUO_BITS].sat_div == SREM_W'(1)) |->
      (hsv.hue == '0 && hsv.saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");

  // Input is never refused while the front stage is empty
  a_take: assert property (@(posedge clk) disable iff (rst)
    !valid_chain[0] |-> !pixel_stall)
    else $error("input stalled with empty front stage");

endmodule

>>> hdl/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front: max/min search and divider setup
// Finds max, min and delta, picks the hue numerator and builds both
// dividend/divisor pairs, registered into the first word of the chain.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rhc_pkg::rhc_pixel_t pixel,
  output logic              ready,
  output logic              out_valid,
  output rhc_pkg::rhc_div_t out_data,
  input  logic              next_ready
);
  import rhc_pkg::*;

  localparam int NUM_W = HREM_W + 1;
  localparam int N_W   = 2 * CH_BITS + 1;

  logic [CH_BITS-1:0]      mx;
  logic [CH_BITS-1:0]      mn;
  logic [CH_BITS-1:0]      delta;
  logic [HREM_W-1:0]       six_d;
  logic signed [NUM_W-1:0] num_raw;
  logic signed [NUM_W-1:0] num_wrap;
  logic [N_W-1:0]          sat_n;
  rhc_div_t                word_next;

  // Max and min; ties resolve toward red then green
  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
  end

  assign delta = mx - mn;
  assign six_d = (HREM_W'(delta) << 2) + (HREM_W'(delta) << 1);

  // Hue numerator by which channel holds the max
  always_comb begin
    if (pixel.red == mx) begin
      num_raw = signed'(NUM_W'(pixel.green)) - signed'(NUM_W'(pixel.blue));
    end else if (pixel.green == mx) begin
      num_raw = signed'(NUM_W'(pixel.blue)) - signed'(NUM_W'(pixel.red))
              + signed'(NUM_W'(delta) << 1);
    end else begin
      num_raw = signed'(NUM_W'(pixel.red)) - signed'(NUM_W'(pixel.green))
              + signed'(NUM_W'(delta) << 2);
    end
  end

  // Wrap a negative numerator into [0, 6*delta)
  assign num_wrap = num_raw[NUM_W-1] ? (num_raw + signed'(NUM_W'(six_d))) : num_raw;

  // Rounded saturation dividend: 2*delta*FS + max, FS*x done as (x<<C) - x
  assign sat_n = (N_W'(delta) << (CH_BITS + 1)) - (N_W'(delta) << 1) + N_W'(mx);

  // First chain word; a gray pixel divides zero by one
  always_comb begin
    word_next.bright = mx;
    word_next.hue_q  = '0;
    if (delta == '0) begin
      word_next.hue_rem = '0;
      word_next.hue_div = HREM_W'(1);
      word_next.sat_rem = '0;
      word_next.sat_div = SREM_W'(1);
      word_next.sat_q   = '0;
    end else begin
      word_next.hue_rem = HREM_W'(num_wrap);
      word_next.hue_div = six_d;
      word_next.sat_rem = sat_n[N_W-1 -: SREM_W];
      word_next.sat_div = {mx, 1'b0};
      word_next.sat_q   = QUO_BITS'(sat_n[CH_BITS-1:0]) << (QUO_BITS - CH_BITS);
    end
  end

  assign ready = !out_valid || next_ready;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= word_next;
    end
  end

endmodule

>>> hdl/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell: one restoring-division step for hue and for saturation
// Shifts one dividend bit into each remainder, subtracts the divisor when it
// fits and shifts the quotient bit in, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module rhc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rhc_pkg::rhc_div_t in_data,
  output logic              ready,
  output logic              out_valid,
  output rhc_pkg::rhc_div_t out_data,
  input  logic              next_ready
);
  import rhc_pkg::*;

  logic [HREM_W:0] hue_trial;
  logic [SREM_W:0] sat_trial;
  logic            hue_fit;
  logic            sat_fit;
  rhc_div_t        word_next;

  // Partial remainders with the next dividend bit appended
  assign hue_trial = {in_data.hue_rem, in_data.hue_q[QUO_BITS-1]};
  assign sat_trial = {in_data.sat_rem, in_data.sat_q[QUO_BITS-1]};
  assign hue_fit   = hue_trial >= {1'b0, in_data.hue_div};
  assign sat_fit   = sat_trial >= {1'b0, in_data.sat_div};

  // Step result
  always_comb begin
    word_next         = in_data;
    word_next.hue_rem = hue_fit ? HREM_W'(hue_trial - {1'b0, in_data.hue_div})
                                : HREM_W'(hue_trial);
    word_next.sat_rem = sat_fit ? SREM_W'(sat_trial - {1'b0, in_data.sat_div})
                                : SREM_W'(sat_trial);
    word_next.hue_q   = {in_data.hue_q[QUO_BITS-2:0], hue_fit};
    word_next.sat_q   = {in_data.sat_q[QUO_BITS-2:0], sat_fit};
  end

  assign ready = !out_valid || next_ready;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      out_data <= word_next;
    end
  end

  // Remainders stay below their divisors
  a_hue_rem: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hue_rem < out_data.hue_div))
    else $error("hue remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sat_rem < out_data.sat_div))
    else $error("saturation remainder not below divisor");

  // A word blocked downstream stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !next_ready) |=> (out_valid && $stable(out_data)))
    else $error("blocked word lost or changed");

endmodule

>>> verif/rgb_to_hsv_convert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_checker: result predictor and comparator
// Watches both channels of the converter. Every pixel word taken is turned into
// the hsv word it must produce, queued in order, and compared field by field
// with each hsv word the converter hands out.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  input  logic                pixel_stall,
  input  rhc_pkg::rhc_pixel_t pixel,
  input  logic                hsv_valid,
  input  logic                hsv_stall,
  input  rhc_pkg::rhc_hsv_t   hsv,
  output int                  errors,
  output int                  waiting,
  output int                  compared
);

  import rhc_pkg::*;

  // hsv words still owed by the converter, oldest first
  rhc_hsv_t owed_hsv [$];

  // Fixed-point RGB to HSV of one pixel
  function automatic rhc_hsv_t hsv_of_pixel(input rhc_pixel_t p);
    longint   r, g, b, top, bot, delta, num, full;
    rhc_hsv_t res;
    full = (longint'(1) << CH_BITS) - 1;
    r = p.red;
    g = p.green;
    b = p.blue;
    top = r;
    bot = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bot) bot = g;
    if (b < bot) bot = b;
    delta = top - bot;
    res = '0;
    res.brightness = CH_BITS'(top);
    // gray pixels keep hue and saturation at zero
    if (delta != 0) begin
      // sector pick: red wins ties, then green
      if (r == top) num = g - b;
      else if (g == top) num = b - r + 2 * delta;
      else num = r - g + 4 * delta;
      if (num < 0) num = num + 6 * delta;
      res.hue = HUE_BITS'((num << HUE_BITS) / (6 * delta));
      // rounded to nearest, halves up
      res.saturation = CH_BITS'((2 * delta * full + top) / (2 * top));
    end
    return res;
  endfunction

  // Compare on every hsv word taken, queue a prediction for every pixel taken
  always @(posedge clk) begin : watch
    rhc_hsv_t want;
    if (!rst) begin
      if (hsv_valid && !hsv_stall) begin
        if (owed_hsv.size() == 0) begin
          $display("%0t: unexpected hsv word, expected none, got %h", $time, hsv);
          errors++;
        end else begin
          want = owed_hsv.pop_front();
          compared++;
          if (want.hue != hsv.hue) begin
            $display("%0t: hue mismatch, expected %0d, got %0d", $time, want.hue, hsv.hue);
            errors++;
          end
          if (want.saturation != hsv.saturation) begin
            $display("%0t: saturation mismatch, expected %0d, got %0d",
                     $time, want.saturation, hsv.saturation);
            errors++;
          end
          if (want.brightness != hsv.brightness) begin
            $display("%0t: brightness mismatch, expected %0d, got %0d",
                     $time, want.brightness, hsv.brightness);
            errors++;
          end
        end
      end
      if (pixel_valid && !pixel_stall) owed_hsv.push_back(hsv_of_pixel(pixel));
      waiting = owed_hsv.size();
    end
  end

endmodule

>>> verif/rgb_to_hsv_convert_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core_tb: testbench for the RGB to HSV converter
// Drives a directed set of corner pixels, then random pixels biased toward
// gray, tied and near-equal channels, with random gaps on the pixel side and
// random back-pressure on the hsv side. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_core_tb;

  import rhc_pkg::*;

  localparam int LATENCY       = 1 + QUO_BITS;
  localparam int FULL          = (1 << CH_BITS) - 1;
  localparam int RANDOM_PIXELS = 600;
  localparam int CALM_TAIL     = 100;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       pixel_valid = 1'b0;
  logic       pixel_stall;
  rhc_pixel_t pixel       = '0;
  logic       hsv_valid;
  logic       hsv_stall   = 1'b0;
  rhc_hsv_t   hsv;

  int errors;
  int waiting;
  int compared;
  int sent;
  int directed_count;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  rgb_to_hsv_convert_core dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
  );

  rgb_to_hsv_convert_checker hsv_check (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv),
    .errors      (errors),
    .waiting     (waiting),
    .compared    (compared)
  );

  function automatic rhc_pixel_t make_pixel(input int r, input int g, input int b);
    rhc_pixel_t p;
    p.red   = CH_BITS'(r);
    p.green = CH_BITS'(g);
    p.blue  = CH_BITS'(b);
    return p;
  endfunction

  // Random pixel: half uniform, the rest gray, tied, extreme, near-equal or near-black
  function automatic rhc_pixel_t rand_pixel();
    int kind;
    int base;
    int ch [3];
    kind = $urandom_range(0, 9);
    base = $urandom_range(0, FULL);
    for (int i = 0; i < 3; i++) begin
      case (kind)
        5: ch[i] = base;
        6: ch[i] = ($urandom_range(0, 1) != 0) ? base : $urandom_range(0, base);
        7: begin
          case ($urandom_range(0, 2))
            0: ch[i] = 0;
            1: ch[i] = FULL;
            default: ch[i] = $urandom_range(0, FULL);
          endcase
        end
        8: begin
          ch[i] = base + $urandom_range(0, 6) - 3;
          if (ch[i] < 0) ch[i] = 0;
          if (ch[i] > FULL) ch[i] = FULL;
        end
        9: ch[i] = $urandom_range(0, 3);
        default: ch[i] = $urandom_range(0, FULL);
      endcase
    end
    return make_pixel(ch[0], ch[1], ch[2]);
  endfunction

  // Offer one pixel word, maybe after an idle burst, and wait until taken
  task automatic send_pixel(input rhc_pixel_t p);
    if (!calm && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sent++;
  endtask

  // hsv back-pressure: random bursts of stall and of flow
  initial begin : hsv_sink
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) hsv_stall <= 1'b1;
      else hsv_stall <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    rhc_pixel_t directed [$];
    // gray cases, black included
    directed.push_back(make_pixel(0, 0, 0));
    directed.push_back(make_pixel(FULL, FULL, FULL));
    directed.push_back(make_pixel(128, 128, 128));
    // primaries and secondaries, ties for the maximum
    directed.push_back(make_pixel(FULL, 0, 0));
    directed.push_back(make_pixel(0, FULL, 0));
    directed.push_back(make_pixel(0, 0, FULL));
    directed.push_back(make_pixel(FULL, FULL, 0));
    directed.push_back(make_pixel(0, FULL, FULL));
    directed.push_back(make_pixel(FULL, 0, FULL));
    directed.push_back(make_pixel(FULL, FULL, 254));
    // red max with blue above green: hue wraps
    directed.push_back(make_pixel(FULL, 0, 1));
    // saturation lands on an exact half, then assorted hues and saturations
    directed.push_back(make_pixel(2, 1, 1));
    directed.push_back(make_pixel(1, 0, 0));
    directed.push_back(make_pixel(0, 1, 0));
    directed.push_back(make_pixel(0, 0, 1));
    directed.push_back(make_pixel(FULL, 254, 254));
    directed.push_back(make_pixel(200, 100, 50));
    directed.push_back(make_pixel(50, 200, 100));
    directed.push_back(make_pixel(100, 50, 200));
    directed.push_back(make_pixel(FULL, 128, 0));
    directed.push_back(make_pixel(1, FULL, 254));
    directed.push_back(make_pixel(170, 85, FULL));
    directed_count = directed.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_pixel(directed[i]);
    for (int k = 0; k < RANDOM_PIXELS; k++) begin
      if (k == RANDOM_PIXELS - CALM_TAIL) calm = 1'b1;
      send_pixel(rand_pixel());
    end
    pixel_valid <= 1'b0;

    // drain, then wait longer than the pipeline for stray words
    while (waiting != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Covered %0d pixels (%0d directed corners), %0d hsv words compared",
             sent, directed_count, compared);
    $display("with random input gaps and output stalls, then a gap-free tail");
    if (waiting != 0) $display("%0t: %0d hsv words never arrived", $time, waiting);
    if (errors == 0 && waiting == 0) begin
      $display("PASS rgb_to_hsv_convert_core");
    end else begin
      $display("FAIL rgb_to_hsv_convert_core");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1000000;
    $display("FAIL rgb_to_hsv_convert_core");
    $finish;
  end

endmodule
